>>> sv/lgs_pkg.sv
// shared types, constants and cell-update functions for the life generation step
// no dependencies
package lgs_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 1024;
    localparam int CFG_W    = 11;
    localparam int NROWS_W  = 11;
    localparam int NCOLS_W  = 7;
    localparam int IDX_W    = 10;

    typedef logic [0:0]          cfg_addr_t;
    typedef logic [MAX_COLS-1:0] row_t;

    localparam cfg_addr_t CFG_NUM_ROWS = 1'b0;
    localparam cfg_addr_t CFG_NUM_COLS = 1'b1;

    // one queued job: the three rows in view plus what to emit
    typedef struct packed {
        row_t             up;
        row_t             mid;
        row_t             down;
        logic [IDX_W-1:0] idx;
        logic             emit_a;   // next state of the row above the new one
        logic             emit_b;   // next state of the new row, dead row below
    } cmd_t;

    typedef struct packed {
        row_t             cells;
        logic [IDX_W-1:0] idx;
        logic             last;
    } res_t;

    // b3/s23 over a row, dead cells beyond both edges
    function automatic row_t evolve(row_t up, row_t mid, row_t down);
        logic [MAX_COLS+1:0] u;
        logic [MAX_COLS+1:0] m;
        logic [MAX_COLS+1:0] d;
        logic [3:0]          n;
        row_t                res;
        u   = {1'b0, up, 1'b0};
        m   = {1'b0, mid, 1'b0};
        d   = {1'b0, down, 1'b0};
        res = '0;
        for (int k = 0; k < MAX_COLS; k++) begin
            n = 4'(u[k]) + 4'(u[k+1]) + 4'(u[k+2])
              + 4'(m[k]) + 4'(m[k+2])
              + 4'(d[k]) + 4'(d[k+1]) + 4'(d[k+2]);
            res[k] = (n == 4'd3) || ((n == 4'd2) && m[k+1]);
        end
        return res;
    endfunction

    function automatic row_t col_mask(logic [NCOLS_W-1:0] nc);
        logic [NCOLS_W-1:0] c;
        row_t               msk;
        c = (nc == '0) ? NCOLS_W'(1) : nc;
        if (c >= NCOLS_W'(MAX_COLS))
            msk = '1;
        else
            msk = (row_t'(1) << c) - row_t'(1);
        return msk;
    endfunction

    function automatic logic [NROWS_W-1:0] eff_rows(logic [NROWS_W-1:0] nr);
        logic [NROWS_W-1:0] r;
        if (nr == '0)
            r = NROWS_W'(1);
        else if (nr > NROWS_W'(MAX_ROWS))
            r = NROWS_W'(MAX_ROWS);
        else
            r = nr;
        return r;
    endfunction

endpackage

>>> sv/lgs_front.sv
// front end: takes row beats, keeps the two previous rows and the row count
// depends on lgs_pkg
module lgs_front
    import lgs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  row_t               row_cells,
    input  row_t               mask,
    input  logic [NROWS_W-1:0] rows_eff,
    input  logic               q_full,
    output logic               full,
    output logic               cmd_push,
    output cmd_t               cmd
);

    row_t             upper_reg, upper_next;
    row_t             middle_reg, middle_next;
    logic [IDX_W-1:0] rows_seen_reg, rows_seen_next;

    logic accept;
    logic last;
    logic first;
    row_t row_m;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign row_m  = row_cells & mask;
    assign first  = (rows_seen_reg == '0);
    assign last   = (NROWS_W'(rows_seen_reg) + NROWS_W'(1)) >= rows_eff;

    assign cmd.up     = upper_reg;
    assign cmd.mid    = middle_reg;
    assign cmd.down   = row_m;
    assign cmd.idx    = rows_seen_reg;
    assign cmd.emit_a = !first;
    assign cmd.emit_b = last;
    // the first row of a longer frame yields nothing yet
    assign cmd_push   = accept && (!first || last);

    always_comb
    begin
        upper_next     = upper_reg;
        middle_next    = middle_reg;
        rows_seen_next = rows_seen_reg;
        if (accept)
        begin
            if (last)
            begin
                upper_next     = '0;
                middle_next    = '0;
                rows_seen_next = '0;
            end
            else
            begin
                upper_next     = middle_reg;
                middle_next    = row_m;
                rows_seen_next = rows_seen_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg     <= '0;
            middle_reg    <= '0;
            rows_seen_reg <= '0;
        end
        else
        begin
            upper_reg     <= upper_next;
            middle_reg    <= middle_next;
            rows_seen_reg <= rows_seen_next;
        end
    end

endmodule

>>> sv/lgs_cmd_queue.sv
// two-entry job queue between the front end and the back end
// depends on lgs_pkg
module lgs_cmd_queue
    import lgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t cmd_out
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cmd_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/lgs_back.sv
// back end: runs the cell update for each job and queues the result rows
// depends on lgs_pkg
module lgs_back
    import lgs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_empty,
    input  cmd_t             cmd,
    input  row_t             mask,
    output logic             cmd_pop,
    output logic             empty,
    input  logic             pop,
    output row_t             next_cells,
    output logic [IDX_W-1:0] row_index,
    output logic             frame_last
);

    logic       phase_reg, phase_next;
    res_t       out_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    logic go;
    logic do_b;
    logic do_pop;
    row_t op_up;
    row_t op_mid;
    row_t op_down;
    res_t res;

    assign go     = !cmd_empty && (count_reg != 2'd2);
    // second half of a two-result job, or a job with only the final row
    assign do_b   = phase_reg || !cmd.emit_a;
    assign op_up  = do_b ? cmd.mid  : cmd.up;
    assign op_mid = do_b ? cmd.down : cmd.mid;
    assign op_down = do_b ? '0      : cmd.down;

    // rows kept from before a column change are cut to the current width
    assign res.cells = evolve(op_up & mask, op_mid & mask, op_down & mask) & mask;
    assign res.idx   = do_b ? cmd.idx : (cmd.idx - IDX_W'(1));
    assign res.last  = do_b;

    assign cmd_pop = go && (do_b || !cmd.emit_b);

    assign empty      = (count_reg == 2'd0);
    assign do_pop     = pop && !empty;
    assign next_cells = out_reg[rd_ptr_reg].cells;
    assign row_index  = out_reg[rd_ptr_reg].idx;
    assign frame_last = out_reg[rd_ptr_reg].last;

    always_comb
    begin
        phase_next  = go ? (!do_b && cmd.emit_b) : phase_reg;
        wr_ptr_next = wr_ptr_reg ^ go;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(go) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (go)
            out_reg[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // a split job stays at the queue head until its second result is out
    a_phase_holds_job: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (!cmd_empty && cmd.emit_a && cmd.emit_b))
        else $error("second phase without a two-result job");

    a_phase_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && go) |=> !phase_reg)
        else $error("second phase did not end");

    a_phase_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !do_b && cmd.emit_b) |-> !cmd_pop)
        else $error("job dropped after its first result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue overrun");

endmodule

>>> sv/life_generation_step.sv
// life_generation_step: one b3/s23 generation, one row beat in per cycle while full is low
// path: a beat's job is registered in the job queue, its results in the result queue,
// a frame's closing result following the one for the row above it
// throughput: one row per cycle while full is low; a final row with a row above it yields
// two results, hidden unless the next beat opens a single-row frame, whose job then waits
// reset: asynchronous, active low; clears rows, row count and queues, num_rows=1, num_cols=64
module life_generation_step
    import lgs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_addr_t        cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             push,
    output logic             full,
    input  row_t             row_cells,
    output logic             empty,
    input  logic             pop,
    output row_t             next_cells,
    output logic [IDX_W-1:0] row_index,
    output logic             frame_last
);

    logic [NROWS_W-1:0] num_rows_reg, num_rows_next;
    logic [NCOLS_W-1:0] num_cols_reg, num_cols_next;

    row_t               mask;
    logic [NROWS_W-1:0] rows_eff;

    logic cmd_push;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    cmd_t cmd_in;
    cmd_t cmd_head;

    assign mask     = col_mask(num_cols_reg);
    assign rows_eff = eff_rows(num_rows_reg);

    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_NUM_ROWS: num_rows_next = cfg_wdata[NROWS_W-1:0];
                CFG_NUM_COLS: num_cols_next = cfg_wdata[NCOLS_W-1:0];
                default:      num_rows_next = num_rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= NROWS_W'(1);
            num_cols_reg <= NCOLS_W'(MAX_COLS);
        end
        else
        begin
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
        end
    end

    lgs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .row_cells (row_cells),
        .mask      (mask),
        .rows_eff  (rows_eff),
        .q_full    (cmd_full),
        .full      (full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    lgs_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .cmd_in  (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .empty   (cmd_empty),
        .cmd_out (cmd_head)
    );

    lgs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd        (cmd_head),
        .mask       (mask),
        .cmd_pop    (cmd_pop),
        .empty      (empty),
        .pop        (pop),
        .next_cells (next_cells),
        .row_index  (row_index),
        .frame_last (frame_last)
    );

endmodule
